// File: src/isec_pkg.sv
`default_nettype none
package isec_pkg;

   typedef struct packed {
      logic valid;
      logic hit;
      logic dzero;
      logic neg_x;
      logic neg_y;
   } ctl_type;

endpackage
`default_nettype wire

// File: src/segment_intersection_test_unit.sv
// Segment intersection test unit.
// Input channel: drive the eight endpoint coordinates on the req_ ports and
// raise start; the beat is taken at each clock edge with start high and busy
// low. busy is always low, so a new beat may be offered every cycle.
// Result channel: rsp_valid is high for exactly one cycle per beat, carrying
// rsp_hit and the intercept on rsp_cross_x / rsp_cross_y (zero on a miss,
// segment A's start on a collinear hit). Results come out in beat order.
// Throughput: one beat a cycle. Six front stages form differences, products,
// the cross terms d, s, t, the hit test and the intercept numerators; a chain
// of COORD_WIDTH divider cells then resolves one quotient bit each, followed
// by one output register.
// Reset clears all valid bits; beats in flight are dropped. The receiver
// cannot stall, so rsp_valid must be taken in the cycle it is shown.
`default_nettype none
module segment_intersection_test_unit #(
   parameter int COORD_WIDTH = 16
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         start,
   output logic                        busy,
   input  wire  signed [COORD_WIDTH-1:0] req_a_start_x,
   input  wire  signed [COORD_WIDTH-1:0] req_a_start_y,
   input  wire  signed [COORD_WIDTH-1:0] req_a_end_x,
   input  wire  signed [COORD_WIDTH-1:0] req_a_end_y,
   input  wire  signed [COORD_WIDTH-1:0] req_b_start_x,
   input  wire  signed [COORD_WIDTH-1:0] req_b_start_y,
   input  wire  signed [COORD_WIDTH-1:0] req_b_end_x,
   input  wire  signed [COORD_WIDTH-1:0] req_b_end_y,
   output logic                        rsp_valid,
   output logic                        rsp_hit,
   output logic signed [COORD_WIDTH-1:0] rsp_cross_x,
   output logic signed [COORD_WIDTH-1:0] rsp_cross_y
);

   localparam int W   = COORD_WIDTH;
   localparam int DW  = 2 * W + 3;
   localparam int NW  = 3 * W + 5;
   localparam int LAT = W + 7;

   isec_pkg::ctl_type    ctl_c   [W+1];
   logic        [NW-1:0] rem_x_c [W+1];
   logic        [NW-1:0] rem_y_c [W+1];
   logic        [DW-1:0] den_c   [W+1];
   logic        [W-1:0]  q_x_c   [W+1];
   logic        [W-1:0]  q_y_c   [W+1];
   logic signed [W-1:0]  base_x_c[W+1];
   logic signed [W-1:0]  base_y_c[W+1];

   logic                 valid_ff, hit_ff;
   logic signed [W-1:0]  cx_ff, cy_ff;
   logic signed [W-1:0]  qx_signed, qy_signed;
   isec_pkg::ctl_type    last;

   assign busy = 1'b0;

   isec_front #(.W(W), .DW(DW), .NW(NW)) u_front (
      .clock  (clock),
      .reset  (reset),
      .beat   (start && !busy),
      .p0x    (req_a_start_x),
      .p0y    (req_a_start_y),
      .p1x    (req_a_end_x),
      .p1y    (req_a_end_y),
      .p2x    (req_b_start_x),
      .p2y    (req_b_start_y),
      .p3x    (req_b_end_x),
      .p3y    (req_b_end_y),
      .ctl_out(ctl_c[0]),
      .mag_x  (rem_x_c[0]),
      .mag_y  (rem_y_c[0]),
      .mag_d  (den_c[0]),
      .base_x (base_x_c[0]),
      .base_y (base_y_c[0])
   );

   assign q_x_c[0] = '0;
   assign q_y_c[0] = '0;

   for (genvar k = 0; k < W; k++) begin : g_cell
      isec_div_cell #(.W(W), .DW(DW), .NW(NW), .IDX(W - 1 - k)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctl_i   (ctl_c[k]),
         .rem_x_i (rem_x_c[k]),
         .rem_y_i (rem_y_c[k]),
         .den_i   (den_c[k]),
         .q_x_i   (q_x_c[k]),
         .q_y_i   (q_y_c[k]),
         .base_x_i(base_x_c[k]),
         .base_y_i(base_y_c[k]),
         .ctl_o   (ctl_c[k+1]),
         .rem_x_o (rem_x_c[k+1]),
         .rem_y_o (rem_y_c[k+1]),
         .den_o   (den_c[k+1]),
         .q_x_o   (q_x_c[k+1]),
         .q_y_o   (q_y_c[k+1]),
         .base_x_o(base_x_c[k+1]),
         .base_y_o(base_y_c[k+1])
      );
   end

   assign last      = ctl_c[W];
   assign qx_signed = last.neg_x ? W'(-q_x_c[W]) : q_x_c[W];
   assign qy_signed = last.neg_y ? W'(-q_y_c[W]) : q_y_c[W];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= last.valid;
      end
   end

   always_ff @(posedge clock) begin
      hit_ff <= last.hit;
      if (!last.hit) begin
         cx_ff <= '0;
         cy_ff <= '0;
      end else if (last.dzero) begin
         cx_ff <= base_x_c[W];
         cy_ff <= base_y_c[W];
      end else begin
         cx_ff <= qx_signed;
         cy_ff <= qy_signed;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_hit     = hit_ff;
   assign rsp_cross_x = cx_ff;
   assign rsp_cross_y = cy_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_valid)
      else $error("result missing after accepted beat");

   a_idle: assert property (@(posedge clock) disable iff (reset)
      !$past(start && !busy, LAT) |-> !rsp_valid)
      else $error("result without accepted beat");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |-> (rsp_cross_x == '0 && rsp_cross_y == '0))
      else $error("nonzero intercept on a miss");

endmodule
`default_nettype wire

// File: src/isec_front.sv
`default_nettype none
module isec_front #(
   parameter int W  = 16,
   parameter int DW = 2 * W + 3,
   parameter int NW = 3 * W + 5
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      beat,
   input  wire  signed [W-1:0]      p0x,
   input  wire  signed [W-1:0]      p0y,
   input  wire  signed [W-1:0]      p1x,
   input  wire  signed [W-1:0]      p1y,
   input  wire  signed [W-1:0]      p2x,
   input  wire  signed [W-1:0]      p2y,
   input  wire  signed [W-1:0]      p3x,
   input  wire  signed [W-1:0]      p3y,
   output isec_pkg::ctl_type        ctl_out,
   output logic        [NW-1:0]     mag_x,
   output logic        [NW-1:0]     mag_y,
   output logic        [DW-1:0]     mag_d,
   output logic signed [W-1:0]      base_x,
   output logic signed [W-1:0]      base_y
);

   localparam int PW = 2 * W + 2;
   localparam int HW = W + 2;
   localparam int QW = 2 * W + 3;

   // stage 1: differences
   logic v1_ff;
   logic signed [W:0]   s1x_ff, s1y_ff, s2x_ff, s2y_ff, ox_ff, oy_ff;
   logic signed [W-1:0] a0x_ff, a0y_ff;

   // stage 2: products
   logic v2_ff;
   logic signed [PW-1:0] m_d1_ff, m_d2_ff, m_s1_ff, m_s2_ff, m_t1_ff, m_t2_ff;
   logic signed [W:0]    b1x_ff, b1y_ff;
   logic signed [W-1:0]  b0x_ff, b0y_ff;

   // stage 3: d, s, t
   logic v3_ff;
   logic signed [DW-1:0] d_ff, s_ff, t_ff;
   logic signed [W:0]    c1x_ff, c1y_ff;
   logic signed [W-1:0]  c0x_ff, c0y_ff;

   // stage 4: partial products, magnitudes
   logic v4_ff;
   logic signed [QW-1:0] px_hi_ff, px_lo_ff, py_hi_ff, py_lo_ff;
   logic signed [QW-1:0] tx_hi_ff, tx_lo_ff, ty_hi_ff, ty_lo_ff;
   logic        [DW-1:0] ad_ff, as_ff, at_ff;
   logic                 sgn_ok_ff, dneg4_ff, dz4_ff;
   logic signed [W-1:0]  e0x_ff, e0y_ff;

   // stage 5: numerators, hit
   logic v5_ff;
   logic signed [NW-1:0] nx_ff, ny_ff;
   logic        [DW-1:0] ad5_ff;
   logic                 hit5_ff, dneg5_ff, dz5_ff;
   logic signed [W-1:0]  f0x_ff, f0y_ff;

   // stage 6: magnitudes
   isec_pkg::ctl_type    ctl_ff;
   logic        [NW-1:0] mx_ff, my_ff;
   logic        [DW-1:0] md_ff;
   logic signed [W-1:0]  g0x_ff, g0y_ff;

   logic signed [HW-1:0] d_hi, d_lo, t_hi, t_lo;
   logic signed [NW-1:0] nx_in, ny_in;

   assign d_hi = d_ff[DW-1:W+1];
   assign d_lo = $signed({1'b0, d_ff[W:0]});
   assign t_hi = t_ff[DW-1:W+1];
   assign t_lo = $signed({1'b0, t_ff[W:0]});

   assign nx_in = ((NW'(px_hi_ff) + NW'(tx_hi_ff)) <<< (W + 1))
                  + NW'(px_lo_ff) + NW'(tx_lo_ff);
   assign ny_in = ((NW'(py_hi_ff) + NW'(ty_hi_ff)) <<< (W + 1))
                  + NW'(py_lo_ff) + NW'(ty_lo_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         v4_ff  <= 1'b0;
         v5_ff  <= 1'b0;
         ctl_ff <= '0;
      end else begin
         v1_ff        <= beat;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         v5_ff        <= v4_ff;
         ctl_ff.valid <= v5_ff;
         ctl_ff.hit   <= hit5_ff;
         ctl_ff.dzero <= dz5_ff;
         ctl_ff.neg_x <= nx_ff[NW-1] ^ dneg5_ff;
         ctl_ff.neg_y <= ny_ff[NW-1] ^ dneg5_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1x_ff <= $signed({p1x[W-1], p1x}) - $signed({p0x[W-1], p0x});
      s1y_ff <= $signed({p1y[W-1], p1y}) - $signed({p0y[W-1], p0y});
      s2x_ff <= $signed({p3x[W-1], p3x}) - $signed({p2x[W-1], p2x});
      s2y_ff <= $signed({p3y[W-1], p3y}) - $signed({p2y[W-1], p2y});
      ox_ff  <= $signed({p0x[W-1], p0x}) - $signed({p2x[W-1], p2x});
      oy_ff  <= $signed({p0y[W-1], p0y}) - $signed({p2y[W-1], p2y});
      a0x_ff <= p0x;
      a0y_ff <= p0y;

      m_d1_ff <= s1x_ff * s2y_ff;
      m_d2_ff <= s2x_ff * s1y_ff;
      m_s1_ff <= s1x_ff * oy_ff;
      m_s2_ff <= s1y_ff * ox_ff;
      m_t1_ff <= s2x_ff * oy_ff;
      m_t2_ff <= s2y_ff * ox_ff;
      b1x_ff  <= s1x_ff;
      b1y_ff  <= s1y_ff;
      b0x_ff  <= a0x_ff;
      b0y_ff  <= a0y_ff;

      d_ff   <= DW'(m_d1_ff) - DW'(m_d2_ff);
      s_ff   <= DW'(m_s1_ff) - DW'(m_s2_ff);
      t_ff   <= DW'(m_t1_ff) - DW'(m_t2_ff);
      c1x_ff <= b1x_ff;
      c1y_ff <= b1y_ff;
      c0x_ff <= b0x_ff;
      c0y_ff <= b0y_ff;

      px_hi_ff  <= c0x_ff * d_hi;
      px_lo_ff  <= c0x_ff * d_lo;
      py_hi_ff  <= c0y_ff * d_hi;
      py_lo_ff  <= c0y_ff * d_lo;
      tx_hi_ff  <= c1x_ff * t_hi;
      tx_lo_ff  <= c1x_ff * t_lo;
      ty_hi_ff  <= c1y_ff * t_hi;
      ty_lo_ff  <= c1y_ff * t_lo;
      ad_ff     <= d_ff[DW-1] ? DW'(-d_ff) : DW'(d_ff);
      as_ff     <= s_ff[DW-1] ? DW'(-s_ff) : DW'(s_ff);
      at_ff     <= t_ff[DW-1] ? DW'(-t_ff) : DW'(t_ff);
      sgn_ok_ff <= (s_ff[DW-1] == d_ff[DW-1]) && (t_ff[DW-1] == d_ff[DW-1]);
      dneg4_ff  <= d_ff[DW-1];
      dz4_ff    <= (d_ff == '0);
      e0x_ff    <= c0x_ff;
      e0y_ff    <= c0y_ff;

      nx_ff    <= nx_in;
      ny_ff    <= ny_in;
      ad5_ff   <= ad_ff;
      hit5_ff  <= sgn_ok_ff && (as_ff <= ad_ff) && (at_ff <= ad_ff);
      dneg5_ff <= dneg4_ff;
      dz5_ff   <= dz4_ff;
      f0x_ff   <= e0x_ff;
      f0y_ff   <= e0y_ff;

      mx_ff  <= nx_ff[NW-1] ? NW'(-nx_ff) : NW'(nx_ff);
      my_ff  <= ny_ff[NW-1] ? NW'(-ny_ff) : NW'(ny_ff);
      md_ff  <= ad5_ff;
      g0x_ff <= f0x_ff;
      g0y_ff <= f0y_ff;
   end

   assign ctl_out = ctl_ff;
   assign mag_x   = mx_ff;
   assign mag_y   = my_ff;
   assign mag_d   = md_ff;
   assign base_x  = g0x_ff;
   assign base_y  = g0y_ff;

endmodule
`default_nettype wire

// File: src/isec_div_cell.sv
`default_nettype none
module isec_div_cell #(
   parameter int W   = 16,
   parameter int DW  = 2 * W + 3,
   parameter int NW  = 3 * W + 5,
   parameter int IDX = 0
) (
   input  wire                      clock,
   input  wire                      reset,
   input  isec_pkg::ctl_type        ctl_i,
   input  wire         [NW-1:0]     rem_x_i,
   input  wire         [NW-1:0]     rem_y_i,
   input  wire         [DW-1:0]     den_i,
   input  wire         [W-1:0]      q_x_i,
   input  wire         [W-1:0]      q_y_i,
   input  wire  signed [W-1:0]      base_x_i,
   input  wire  signed [W-1:0]      base_y_i,
   output isec_pkg::ctl_type        ctl_o,
   output logic        [NW-1:0]     rem_x_o,
   output logic        [NW-1:0]     rem_y_o,
   output logic        [DW-1:0]     den_o,
   output logic        [W-1:0]      q_x_o,
   output logic        [W-1:0]      q_y_o,
   output logic signed [W-1:0]      base_x_o,
   output logic signed [W-1:0]      base_y_o
);

   isec_pkg::ctl_type    ctl_ff;
   logic        [NW-1:0] rem_x_ff, rem_y_ff;
   logic        [DW-1:0] den_ff;
   logic        [W-1:0]  q_x_ff, q_y_ff;
   logic signed [W-1:0]  base_x_ff, base_y_ff;

   logic [NW-1:0] shifted;
   logic          take_x, take_y;

   assign shifted = NW'(den_i) << IDX;
   assign take_x  = (rem_x_i >= shifted);
   assign take_y  = (rem_y_i >= shifted);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_i;
      end
   end

   always_ff @(posedge clock) begin
      rem_x_ff  <= take_x ? rem_x_i - shifted : rem_x_i;
      rem_y_ff  <= take_y ? rem_y_i - shifted : rem_y_i;
      q_x_ff    <= q_x_i | (W'(take_x) << IDX);
      q_y_ff    <= q_y_i | (W'(take_y) << IDX);
      den_ff    <= den_i;
      base_x_ff <= base_x_i;
      base_y_ff <= base_y_i;
   end

   assign ctl_o    = ctl_ff;
   assign rem_x_o  = rem_x_ff;
   assign rem_y_o  = rem_y_ff;
   assign den_o    = den_ff;
   assign q_x_o    = q_x_ff;
   assign q_y_o    = q_y_ff;
   assign base_x_o = base_x_ff;
   assign base_y_o = base_y_ff;

endmodule
`default_nettype wire

// File: tb/tb_segment_intersection_test_unit.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_segment_intersection_test_unit;

   localparam int CW = 16;
   localparam int LATENCY = CW + 7;
   localparam int CYCLE_LIMIT = 200000;

   typedef logic signed [CW-1:0] coord_t;
   typedef struct packed {
      logic   hit;
      coord_t cross_x;
      coord_t cross_y;
   } isec_result_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   coord_t req_a_start_x = '0, req_a_start_y = '0, req_a_end_x = '0, req_a_end_y = '0;
   coord_t req_b_start_x = '0, req_b_start_y = '0, req_b_end_x = '0, req_b_end_y = '0;
   logic rsp_valid, rsp_hit;
   coord_t rsp_cross_x, rsp_cross_y;

   isec_result_t pending_isecs[$];
   int failures = 0;
   int cycle_count = 0;
   logic idle_enable = 1'b1;

   segment_intersection_test_unit #(.COORD_WIDTH(CW)) uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_a_start_x(req_a_start_x), .req_a_start_y(req_a_start_y),
      .req_a_end_x(req_a_end_x), .req_a_end_y(req_a_end_y),
      .req_b_start_x(req_b_start_x), .req_b_start_y(req_b_start_y),
      .req_b_end_x(req_b_end_x), .req_b_end_y(req_b_end_y),
      .rsp_valid(rsp_valid), .rsp_hit(rsp_hit),
      .rsp_cross_x(rsp_cross_x), .rsp_cross_y(rsp_cross_y)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_segment_intersection_test_unit failed");
         $finish;
      end
   end

   function automatic coord_t intercept_coord(longint p0, longint s1, longint t, longint d);
      longint num, q;
      begin
         num = p0 * d + t * s1;
         q = num / d;
         return coord_t'(q);
      end
   endfunction

   function automatic isec_result_t predict_isec(coord_t ax0, coord_t ay0, coord_t ax1,
         coord_t ay1, coord_t bx0, coord_t by0, coord_t bx1, coord_t by1);
      longint s1x, s1y, s2x, s2y, ox, oy, d, s, t, ad, as_, at;
      isec_result_t r;
      begin
         s1x = longint'(ax1) - ax0; s1y = longint'(ay1) - ay0;
         s2x = longint'(bx1) - bx0; s2y = longint'(by1) - by0;
         ox = longint'(ax0) - bx0; oy = longint'(ay0) - by0;
         d = s1x * s2y - s2x * s1y;
         s = s1x * oy - s1y * ox;
         t = s2x * oy - s2y * ox;
         ad = d < 0 ? -d : d;
         as_ = s < 0 ? -s : s;
         at = t < 0 ? -t : t;
         r = '0;
         r.hit = ((s < 0) == (d < 0)) && (as_ <= ad) && ((t < 0) == (d < 0)) && (at <= ad);
         if (r.hit) begin
            if (d == 0) begin
               r.cross_x = ax0;
               r.cross_y = ay0;
            end else begin
               r.cross_x = intercept_coord(ax0, s1x, t, d);
               r.cross_y = intercept_coord(ay0, s1y, t, d);
            end
         end
         return r;
      end
   endfunction

   always @(posedge clock) begin
      isec_result_t exp_r;
      if (!reset && rsp_valid) begin
         if (pending_isecs.size() == 0) begin
            $error("unexpected result hit=%0d x=%0d y=%0d", rsp_hit, rsp_cross_x, rsp_cross_y);
            failures++;
         end else begin
            exp_r = pending_isecs.pop_front();
            if (rsp_hit !== exp_r.hit) begin
               $error("hit: expected %0d actual %0d", exp_r.hit, rsp_hit);
               failures++;
            end
            if (rsp_cross_x !== exp_r.cross_x) begin
               $error("cross_x: expected %0d actual %0d", exp_r.cross_x, rsp_cross_x);
               failures++;
            end
            if (rsp_cross_y !== exp_r.cross_y) begin
               $error("cross_y: expected %0d actual %0d", exp_r.cross_y, rsp_cross_y);
               failures++;
            end
         end
      end
   end

   task automatic send_segments(coord_t ax0, coord_t ay0, coord_t ax1, coord_t ay1,
         coord_t bx0, coord_t by0, coord_t bx1, coord_t by1);
      int gap;
      begin
         if (idle_enable && $urandom_range(3) == 0) begin
            start <= 1'b0;
            gap = $urandom_range(4, 1);
            repeat (gap) @(negedge clock);
         end
         req_a_start_x <= ax0; req_a_start_y <= ay0;
         req_a_end_x <= ax1;   req_a_end_y <= ay1;
         req_b_start_x <= bx0; req_b_start_y <= by0;
         req_b_end_x <= bx1;   req_b_end_y <= by1;
         start <= 1'b1;
         @(posedge clock);
         while (busy) @(posedge clock);
         pending_isecs.push_back(predict_isec(ax0, ay0, ax1, ay1, bx0, by0, bx1, by1));
         @(negedge clock);
      end
   endtask

   function automatic coord_t rand_coord();
      return coord_t'($urandom);
   endfunction

   task automatic test_directed();
      coord_t mx, mn;
      begin
         mx = 16'sh7fff;
         mn = 16'sh8000;
         send_segments(0, 0, 10, 10, 0, 10, 10, 0);
         send_segments(0, 0, 10, 0, 0, 5, 10, 5);
         send_segments(0, 0, 10, 0, 2, 0, 8, 0);
         send_segments(0, 0, 10, 0, 20, 0, 30, 0);
         send_segments(5, 5, 5, 5, 5, 5, 5, 5);
         send_segments(3, 4, 3, 4, 0, 0, 9, 9);
         send_segments(mn, mn, mx, mx, mn, mx, mx, mn);
         send_segments(mx, mn, mn, mx, mn, mn, mx, mx);
         send_segments(mn, mn, mx, mn, mn, mn, mn, mx);
         send_segments(mx, mx, mn, mn, mx, mx, mx, mn);
         send_segments(0, 0, 10, 10, 10, 10, 20, 0);
         send_segments(0, 0, 10, 0, 10, 0, 10, 10);
         send_segments(-7, -3, 5, 9, 4, -8, -6, 7);
         send_segments(0, 0, 3, 1, 1, 2, 2, -1);
         send_segments(0, 0, -3, -1, -1, 2, -2, -1);
         send_segments(mn, 0, mx, 0, 0, mn, 0, mx);
         send_segments(-1, -1, -1, -1, mn, mn, mn, mn);
         send_segments(0, 0, 10, 10, 11, 11, 20, 20);
      end
   endtask

   task automatic test_random(int count);
      coord_t ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
      int span;
      begin
         for (int i = 0; i < count; i++) begin
            ax0 = rand_coord(); ay0 = rand_coord(); ax1 = rand_coord(); ay1 = rand_coord();
            bx0 = rand_coord(); by0 = rand_coord(); bx1 = rand_coord(); by1 = rand_coord();
            case ($urandom_range(3))
               0: begin
                  span = $urandom_range(64, 1);
                  ax0 = coord_t'(int'($urandom_range(2 * span)) - span);
                  ay0 = coord_t'(int'($urandom_range(2 * span)) - span);
                  ax1 = coord_t'(int'($urandom_range(2 * span)) - span);
                  ay1 = coord_t'(int'($urandom_range(2 * span)) - span);
                  bx0 = coord_t'(int'($urandom_range(2 * span)) - span);
                  by0 = coord_t'(int'($urandom_range(2 * span)) - span);
                  bx1 = coord_t'(int'($urandom_range(2 * span)) - span);
                  by1 = coord_t'(int'($urandom_range(2 * span)) - span);
               end
               1: begin
                  bx0 = ax1; by0 = ay0; bx1 = ax0; by1 = ay1;
               end
               2: begin
                  bx0 = ax0 + ax1 - bx1;
                  by0 = ay0 + ay1 - by1;
               end
               default: ;
            endcase
            send_segments(ax0, ay0, ax1, ay1, bx0, by0, bx1, by1);
         end
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(1300);
      idle_enable = 1'b0;
      test_random(250);
      start <= 1'b0;
      while (pending_isecs.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
      if (failures == 0) begin
         $display("tb_segment_intersection_test_unit passed");
      end else begin
         $display("tb_segment_intersection_test_unit failed");
      end
      $finish;
   end

endmodule
`default_nettype wire

// File: files.f
src/isec_pkg.sv
src/isec_front.sv
src/isec_div_cell.sv
src/segment_intersection_test_unit.sv
tb/tb_segment_intersection_test_unit.sv
